/* hw/rtl/xxtea_pkg.sv */
// Shared types, constants and helper functions of the XXTEA block cipher.
`default_nettype none
package xxtea_pkg;

  localparam int MAX_WORDS = 64;
  localparam int ADDR_W    = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int WORD_W    = 32;
  localparam int ROUND_W   = 6;
  localparam int NUM_KEYS  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] XXTEA_DELTA = 32'h9e37_79b9;

  typedef struct packed {
    logic [WORD_W-1:0] data_in;
    logic              last_in;
    logic              direction;
  } in_t;

  typedef struct packed {
    logic [WORD_W-1:0] data_out;
    logic              last_out;
    logic              error_flag;
  } out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_INIT_RD,
    ST_INIT_CAP,
    ST_RD_T,
    ST_RD_N,
    ST_MIX,
    ST_WR,
    ST_OUT_RD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               ram_we;
    logic               wr_sel_upd;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic               cap_tgt;
    logic               cap_carry;
    logic               do_mix;
    logic               do_upd;
    logic               sum_init;
    logic               sum_step;
    logic               dir;
    logic [ROUND_W-1:0] rounds;
    logic [1:0]         key_p;
    logic               out_load;
    logic               out_last;
    logic               out_err;
  } dp_cmd_t;

  // 6 + 52/n for block lengths 2..MAX_WORDS
  function automatic logic [ROUND_W-1:0] rounds_for(input logic [CNT_W-1:0] n);
    logic [ROUND_W-1:0] r;
    case (n) inside
      [7'd53:7'd64]: r = 6'd6;
      [7'd27:7'd52]: r = 6'd7;
      [7'd18:7'd26]: r = 6'd8;
      [7'd14:7'd17]: r = 6'd9;
      [7'd11:7'd13]: r = 6'd10;
      [7'd9:7'd10]:  r = 6'd11;
      7'd8:          r = 6'd12;
      7'd7:          r = 6'd13;
      7'd6:          r = 6'd14;
      7'd5:          r = 6'd16;
      7'd4:          r = 6'd19;
      7'd3:          r = 6'd23;
      7'd2:          r = 6'd32;
      default:       r = 6'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/xxtea_block_cipher.sv */
// XXTEA block cipher top level: n-word block in, n-word block out.
// Loading takes one cycle per word. After the last word, an n-word block (n >= 2) runs
// 6 + 52/n rounds; each word update steps through ST_RD_T, ST_RD_N, ST_MIX and ST_WR
// on the one shared mix unit and single-read word store. Results then leave one word
// at a time; a one-word block skips the rounds. Results cannot be stalled.
// Reset clears the key registers, word count and control state; the word store is not cleared.
`default_nettype none
module xxtea_block_cipher
  import xxtea_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_t                  in_data,
  output logic                      out_strobe,
  output out_t                      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  dp_cmd_t cmd;

  xxtea_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .last_in  (in_data.last_in),
    .direction(in_data.direction),
    .busy     (busy),
    .cmd      (cmd)
  );

  xxtea_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .word_in   (in_data.data_in),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* hw/rtl/xxtea_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module xxtea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/xxtea_ctrl.sv */
// Controller: block loading, round sequencing and result readout.
`default_nettype none
module xxtea_ctrl
  import xxtea_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  input  wire logic    last_in,
  input  wire logic    direction,
  output logic         busy,
  output dp_cmd_t      cmd
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic                mode_r, mode_nxt;
  logic                err_r, err_nxt;
  logic [ROUND_W-1:0]  rounds_r, rounds_nxt;
  logic [ADDR_W-1:0]   p_r, p_nxt;

  logic [CNT_W-1:0]    cnt_m1;
  logic [ADDR_W-1:0]   last_idx;
  logic [ADDR_W-1:0]   nb_idx;
  logic [CNT_W-1:0]    n_blk;
  logic                round_end;

  assign cnt_m1   = count_r - CNT_W'(1);
  assign last_idx = cnt_m1[ADDR_W-1:0];
  assign busy     = (state_r != ST_LOAD);

  always_comb begin
    if (mode_r) begin
      nb_idx    = (p_r == '0) ? last_idx : p_r - ADDR_W'(1);
      round_end = (p_r == '0);
    end else begin
      nb_idx    = (p_r == last_idx) ? '0 : p_r + ADDR_W'(1);
      round_end = (p_r == last_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      ovf_r    <= 1'b0;
      mode_r   <= 1'b0;
      err_r    <= 1'b0;
      rounds_r <= '0;
      p_r      <= '0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      ovf_r    <= ovf_nxt;
      mode_r   <= mode_nxt;
      err_r    <= err_nxt;
      rounds_r <= rounds_nxt;
      p_r      <= p_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    mode_nxt   = mode_r;
    err_nxt    = err_r;
    rounds_nxt = rounds_r;
    p_nxt      = p_r;
    n_blk      = count_r;

    cmd        = '0;
    cmd.dir    = mode_r;
    cmd.rounds = rounds_r;
    cmd.key_p  = p_r[1:0];
    cmd.raddr  = p_r;
    cmd.waddr  = p_r;

    case (state_r)
      ST_LOAD: begin
        if (start) begin
          if (count_r == '0 && !ovf_r) begin
            mode_nxt = direction;
          end
          if (count_r < CNT_W'(MAX_WORDS)) begin
            cmd.ram_we = 1'b1;
            cmd.waddr  = count_r[ADDR_W-1:0];
            n_blk      = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          count_nxt = n_blk;
          if (last_in) begin
            err_nxt = ovf_nxt || (n_blk == CNT_W'(1));
            p_nxt   = '0;
            if (n_blk == CNT_W'(1)) begin
              state_nxt = ST_OUT_RD;
            end else begin
              state_nxt = ST_SETUP;
            end
          end
        end
      end
      ST_SETUP: begin
        rounds_nxt = rounds_for(count_r);
        state_nxt  = ST_INIT_RD;
      end
      ST_INIT_RD: begin
        cmd.raddr    = mode_r ? '0 : last_idx;
        cmd.sum_init = 1'b1;
        p_nxt        = mode_r ? last_idx : '0;
        state_nxt    = ST_INIT_CAP;
      end
      ST_INIT_CAP: begin
        cmd.cap_carry = 1'b1;
        state_nxt     = ST_RD_T;
      end
      ST_RD_T: begin
        state_nxt = ST_RD_N;
      end
      ST_RD_N: begin
        cmd.raddr   = nb_idx;
        cmd.cap_tgt = 1'b1;
        state_nxt   = ST_MIX;
      end
      ST_MIX: begin
        cmd.raddr  = nb_idx;
        cmd.do_mix = 1'b1;
        state_nxt  = ST_WR;
      end
      ST_WR: begin
        cmd.ram_we     = 1'b1;
        cmd.wr_sel_upd = 1'b1;
        cmd.do_upd     = 1'b1;
        state_nxt      = ST_RD_T;
        if (round_end) begin
          if (rounds_r == ROUND_W'(1)) begin
            p_nxt     = '0;
            state_nxt = ST_OUT_RD;
          end else begin
            rounds_nxt   = rounds_r - ROUND_W'(1);
            cmd.sum_step = 1'b1;
            p_nxt        = mode_r ? last_idx : '0;
          end
        end else begin
          p_nxt = mode_r ? p_r - ADDR_W'(1) : p_r + ADDR_W'(1);
        end
      end
      ST_OUT_RD: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_load = 1'b1;
        cmd.out_last = (p_r == last_idx);
        cmd.out_err  = err_r;
        if (p_r == last_idx) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          p_nxt     = '0;
          state_nxt = ST_LOAD;
        end else begin
          p_nxt     = p_r + ADDR_W'(1);
          state_nxt = ST_OUT_RD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/xxtea_dp.sv */
// Datapath: key registers, word store, round sum and the shared mix unit.
`default_nettype none
module xxtea_dp
  import xxtea_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dp_cmd_t              cmd,
  input  wire logic [WORD_W-1:0]    word_in,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output logic                      out_strobe,
  output out_t                      out_data
);

  logic [WORD_W-1:0] key_r [NUM_KEYS];
  logic [WORD_W-1:0] sum_r, sum_nxt;
  logic [WORD_W-1:0] tgt_r;
  logic [WORD_W-1:0] carry_r;
  logic [WORD_W-1:0] mix_r;
  logic              out_valid_r;
  out_t              out_r;

  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] y, z, k, mix_a, mix_b, upd;
  logic [1:0]        key_idx;

  xxtea_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(cmd.waddr),
    .wdata(wdata),
    .raddr(cmd.raddr),
    .rdata(rdata)
  );

  always_comb begin
    y       = cmd.dir ? carry_r : rdata;
    z       = cmd.dir ? rdata : carry_r;
    key_idx = cmd.key_p ^ sum_r[3:2];
    k       = key_r[key_idx];
    mix_a   = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    mix_b   = (sum_r ^ y) + (k ^ z);
    upd     = cmd.dir ? tgt_r - mix_r : tgt_r + mix_r;
    wdata   = cmd.wr_sel_upd ? upd : word_in;
  end

  always_comb begin
    sum_nxt = sum_r;
    if (cmd.sum_init) begin
      sum_nxt = cmd.dir ? WORD_W'(XXTEA_DELTA * WORD_W'(cmd.rounds)) : XXTEA_DELTA;
    end else if (cmd.sum_step) begin
      sum_nxt = cmd.dir ? sum_r - XXTEA_DELTA : sum_r + XXTEA_DELTA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_r[cfg_index] <= cfg_data;
      end
      out_valid_r <= cmd.out_load;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (cmd.cap_tgt) begin
      tgt_r <= rdata;
    end
    if (cmd.cap_carry) begin
      carry_r <= rdata;
    end else if (cmd.do_upd) begin
      carry_r <= upd;
    end
    if (cmd.do_mix) begin
      mix_r <= mix_a ^ mix_b;
    end
    if (cmd.out_load) begin
      out_r.data_out   <= rdata;
      out_r.last_out   <= cmd.out_last;
      out_r.error_flag <= cmd.out_err;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_data   = out_r;

endmodule
`default_nettype wire

/* tb/xxtea_block_cipher_checker.sv */
// Checker for the XXTEA block cipher: predicts every result word from the accepted input words.
module xxtea_block_cipher_checker
  import xxtea_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 busy,
  input  wire in_t                  in_data,
  input  wire logic                 out_strobe,
  input  wire out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  output int                        mismatches,
  output int                        outstanding,
  output int                        words_checked
);

  localparam int ROUND_BASE = 6;
  localparam int ROUND_SPAN = 52;

  logic [WORD_W-1:0] key_words [NUM_KEYS];
  logic [WORD_W-1:0] blk [MAX_WORDS];
  logic [CNT_W-1:0]  blk_len;
  logic              blk_decrypt;
  logic              blk_overflow;
  out_t              cipher_words_q [$];

  function automatic logic [WORD_W-1:0] round_mix(input logic [WORD_W-1:0] y, z, s,
                                                  input logic [1:0] p, e);
    logic [WORD_W-1:0] a, b;
    a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
    b = (s ^ y) + (key_words[p ^ e] ^ z);
    return a ^ b;
  endfunction

  function automatic void encipher(input int n);
    int rounds;
    logic [WORD_W-1:0] s, y, z;
    logic [1:0] e;
    rounds = ROUND_BASE + ROUND_SPAN / n;
    s = '0;
    z = blk[n-1];
    repeat (rounds) begin
      s += XXTEA_DELTA;
      e = s[3:2];
      for (int p = 0; p < n - 1; p++) begin
        y = blk[p+1];
        blk[p] += round_mix(y, z, s, p[1:0], e);
        z = blk[p];
      end
      y = blk[0];
      blk[n-1] += round_mix(y, z, s, 2'(n - 1), e);
      z = blk[n-1];
    end
  endfunction

  function automatic void decipher(input int n);
    int rounds;
    logic [WORD_W-1:0] s, y, z;
    logic [1:0] e;
    rounds = ROUND_BASE + ROUND_SPAN / n;
    s = 32'(XXTEA_DELTA * 32'(rounds));
    y = blk[0];
    repeat (rounds) begin
      e = s[3:2];
      for (int p = n - 1; p > 0; p--) begin
        z = blk[p-1];
        blk[p] -= round_mix(y, z, s, p[1:0], e);
        y = blk[p];
      end
      z = blk[n-1];
      blk[0] -= round_mix(y, z, s, 2'b00, e);
      y = blk[0];
      s -= XXTEA_DELTA;
    end
  endfunction

  function automatic void absorb_word(input in_t t);
    out_t r;
    logic err;
    if (blk_len == 0 && !blk_overflow) blk_decrypt = t.direction;
    if (blk_len < MAX_WORDS) begin
      blk[blk_len[ADDR_W-1:0]] = t.data_in;
      blk_len++;
    end else begin
      blk_overflow = 1'b1;
    end
    if (t.last_in) begin
      err = blk_overflow || (blk_len == 1);
      if (blk_len > 1) begin
        if (blk_decrypt) decipher(blk_len);
        else encipher(blk_len);
      end
      for (int i = 0; i < blk_len; i++) begin
        r.data_out   = blk[i];
        r.last_out   = (i == blk_len - 1);
        r.error_flag = err;
        cipher_words_q.push_back(r);
      end
      blk_len      = '0;
      blk_overflow = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (key_words[i]) key_words[i] = '0;
      blk_len      = '0;
      blk_decrypt  = 1'b0;
      blk_overflow = 1'b0;
      cipher_words_q.delete();
    end else begin
      if (out_strobe) begin
        if (cipher_words_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: data %h last %b err %b",
                     out_data.data_out, out_data.last_out, out_data.error_flag);
        end else begin
          want = cipher_words_q.pop_front();
          if (out_data.data_out !== want.data_out || out_data.last_out !== want.last_out ||
              out_data.error_flag !== want.error_flag) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected data %h last %b err %b, got %h %b %b",
                       words_checked, want.data_out, want.last_out, want.error_flag,
                       out_data.data_out, out_data.last_out, out_data.error_flag);
          end
          words_checked++;
        end
      end
      if (cfg_we) key_words[cfg_index] = cfg_data;
      if (start && !busy) absorb_word(in_data);
    end
    outstanding <= cipher_words_q.size();
  end

endmodule

/* tb/xxtea_block_cipher_test.sv */
// Testbench top for the XXTEA block cipher: drives blocks and keys, reports the verdict.
module xxtea_block_cipher_test;
  import xxtea_pkg::*;

  typedef enum logic [CFG_IDX_W-1:0] {KEY_W0, KEY_W1, KEY_W2, KEY_W3} key_reg_e;

  localparam logic DIR_ENC       = 1'b0;
  localparam logic DIR_DEC       = 1'b1;
  localparam int   CYCLE_LIMIT   = 400000;
  localparam int   SETTLE_CYCLES = 16;
  localparam int   RANDOM_WORDS  = 300;
  localparam int   NUM_PHASES    = 4;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_t                  in_data   = '0;
  logic                 out_strobe;
  out_t                 out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = KEY_W0;
  logic [WORD_W-1:0]    cfg_data  = '0;

  int mismatches, outstanding, words_checked;
  int cycle_cnt       = 0;
  int idle_pct        = 0;
  int words_sent      = 0;
  int blocks_sent     = 0;
  int single_blocks   = 0;
  int overflow_blocks = 0;
  int key_settings    = 0;

  // the receiver cannot hold results off, so only the sender idles
  int phase_idle [NUM_PHASES] = '{0, 82, 0, 17};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  xxtea_block_cipher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  xxtea_block_cipher_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_strobe   (out_strobe),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .words_checked(words_checked)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("xxtea_block_cipher_test: FAIL");
      $finish;
    end
  end

  function automatic int sender_gap();
    int g;
    g = 0;
    while ($urandom_range(99) < idle_pct) g++;
    return g;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic int next_block_len();
    int r;
    if (blocks_sent == 4) return MAX_WORDS;
    if (blocks_sent == 12) return MAX_WORDS + 3;
    r = $urandom_range(99);
    if (r < 8) return 1;
    if (r < 75) return $urandom_range(6, 2);
    if (r < 98) return $urandom_range(20, 7);
    return $urandom_range(MAX_WORDS, 21);
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] word, input logic last, input logic dir);
    int gap;
    in_data <= in_t'{data_in: word, last_in: last, direction: dir};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_block(input int len, input logic dir);
    blocks_sent++;
    if (len == 1) single_blocks++;
    if (len > MAX_WORDS) overflow_blocks++;
    for (int i = 0; i < len; i++)
      send_word(rand_word(), i == len - 1, (i == 0) ? dir : 1'($urandom_range(1)));
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [WORD_W-1:0] w0, w1, w2, w3);
    cfg_we    <= 1'b1;
    cfg_index <= KEY_W0;
    cfg_data  <= w0;
    @(posedge clk);
    cfg_index <= KEY_W1;
    cfg_data  <= w1;
    @(posedge clk);
    cfg_index <= KEY_W2;
    cfg_data  <= w2;
    @(posedge clk);
    cfg_index <= KEY_W3;
    cfg_data  <= w3;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_settings++;
  endtask

  initial begin
    int phase_end;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key (all zero): one-word blocks and shortest blocks at the word extremes
    send_word('0, 1'b1, DIR_ENC);
    send_word('1, 1'b1, DIR_DEC);
    send_word('0, 1'b0, DIR_ENC);
    send_word('1, 1'b1, DIR_DEC);
    send_word('1, 1'b0, DIR_DEC);
    send_word('0, 1'b1, DIR_ENC);
    drain();
    load_key('1, '1, '1, '1);
    send_word('1, 1'b0, DIR_ENC);
    send_word('1, 1'b0, DIR_DEC);
    send_word('1, 1'b1, DIR_DEC);
    send_word('0, 1'b0, DIR_DEC);
    send_word('0, 1'b0, DIR_ENC);
    send_word('0, 1'b1, DIR_ENC);
    drain();
    load_key(32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210);
    send_word($urandom(), 1'b0, DIR_ENC);
    send_word($urandom(), 1'b1, DIR_ENC);
    send_word($urandom(), 1'b0, DIR_DEC);
    send_word($urandom(), 1'b1, DIR_DEC);
    send_word($urandom(), 1'b1, DIR_DEC);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == 1) load_key('0, '1, '0, '1);
      else load_key($urandom(), $urandom(), $urandom(), $urandom());
      idle_pct  = phase_idle[ph];
      phase_end = words_sent + RANDOM_WORDS / NUM_PHASES;
      while (words_sent < phase_end) begin
        send_block(next_block_len(), 1'($urandom_range(1)));
        if ($urandom_range(9) == 0) drain();
      end
    end
    drain();

    $display("sent %0d words in %0d blocks (%0d one-word, %0d past the word limit), %0d keys",
             words_sent, blocks_sent, single_blocks, overflow_blocks, key_settings);
    $display("compared %0d result words, %0d mismatches", words_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("xxtea_block_cipher_test: PASS");
    end else begin
      $display("xxtea_block_cipher_test: FAIL");
    end
    $finish;
  end

endmodule
